### design/rlr_pkg.sv
// Shared types and constants for the ranged LCG random block.
// Used by rlr_ctrl, rlr_dp, the top level and the checker. No dependencies.
`timescale 1ns / 1ps

package rlr_pkg;

  localparam int unsigned STATE_W  = 32;
  localparam int unsigned DRAW_W   = 15;
  localparam int unsigned DRAW_LSB = 16;
  localparam int unsigned SPAN_W   = STATE_W + 1;
  localparam int unsigned CNT_W    = $clog2(DRAW_W);

  localparam logic [STATE_W-1:0] LCG_MUL  = 32'h0003_43fd;
  localparam logic [STATE_W-1:0] LCG_ADD  = 32'h0026_9ec3;
  localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(DRAW_W - 1);

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_SEED  = 2'd1,
    OP_RANGE = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_LOW,
    RES_DRAW,
    RES_SUM
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     advance;
    logic     div_step;
    logic     load_res;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic bounds_eq;
    logic div_last;
  } dp_stat_t;

endpackage

### design/rlr_ctrl.sv
// Sequencing FSM for the ranged LCG random block.
// Depends on rlr_pkg; drives rlr_dp through ctrl_cmd_t, owns the output valid.
`timescale 1ns / 1ps

module rlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  rlr_pkg::op_t      in_op,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rlr_pkg::dp_stat_t stat,
  output rlr_pkg::ctrl_cmd_t cmd
);
  import rlr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   out_free;

  assign in_xfer  = in_tvalid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_op == OP_DRAW || in_op == OP_RANGE)) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (stat.op == OP_RANGE && !stat.bounds_eq) state_nxt = ST_DIV;
        else                                        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_ADD;
      end
      ST_ADD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = RES_DRAW;
    unique case (state_r)
      ST_IDLE: cmd.capture = in_xfer;
      ST_STEP: begin
        cmd.advance = !(stat.op == OP_RANGE && stat.bounds_eq);
        cmd.load_res = (stat.op != OP_RANGE) || stat.bounds_eq;
        cmd.res_sel  = (stat.op == OP_RANGE) ? RES_LOW : RES_DRAW;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_ADD: begin
        cmd.load_res = 1'b1;
        cmd.res_sel  = RES_SUM;
      end
      ST_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### design/rlr_dp.sv
// Datapath for the ranged LCG random block: generator state, bound ordering,
// bit-serial remainder and output register. Depends on rlr_pkg.
`timescale 1ns / 1ps

module rlr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlr_pkg::ctrl_cmd_t   cmd,
  input  rlr_pkg::op_t         in_op,
  input  logic [31:0]          in_seed,
  input  logic signed [31:0]   in_low,
  input  logic signed [31:0]   in_high,
  output rlr_pkg::dp_stat_t    stat,
  output logic [31:0]          out_value
);
  import rlr_pkg::*;

  logic [STATE_W-1:0]        lcg_r, lcg_nxt;
  logic [DRAW_W-1:0]         draw_nxt;
  op_t                       op_r;
  logic                      eq_r;
  logic signed [STATE_W-1:0] lo_r, hi_r;
  logic [SPAN_W-1:0]         span_r;
  logic [DRAW_W-1:0]         dvd_r;
  logic [DRAW_W-1:0]         rem_r;
  logic [DRAW_W-1:0]         rem_sh;
  logic [CNT_W-1:0]          cnt_r;
  logic [STATE_W-1:0]        res_r, res_nxt;
  logic [STATE_W-1:0]        out_r;

  assign lcg_nxt  = lcg_r * LCG_MUL + LCG_ADD;
  assign draw_nxt = lcg_nxt[DRAW_LSB +: DRAW_W];

  // restoring remainder, one dividend bit per step; partial value stays 15 bits
  assign rem_sh = {rem_r[DRAW_W-2:0], dvd_r[DRAW_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r <= '0;
    end else if (cmd.capture && in_op == OP_SEED) begin
      lcg_r <= in_seed;
    end else if (cmd.advance) begin
      lcg_r <= lcg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      eq_r <= (in_low == in_high);
      lo_r <= (in_low > in_high) ? in_high : in_low;
      hi_r <= (in_low > in_high) ? in_low : in_high;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      span_r <= SPAN_W'({hi_r[STATE_W-1], hi_r} - {lo_r[STATE_W-1], lo_r});
      dvd_r  <= draw_nxt;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DRAW_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if ({(SPAN_W - DRAW_W)'(0), rem_sh} >= span_r)
        rem_r <= rem_sh - span_r[DRAW_W-1:0];
      else
        rem_r <= rem_sh;
    end
  end

  always_comb begin
    case (cmd.res_sel)
      RES_LOW:  res_nxt = lo_r;
      RES_SUM:  res_nxt = lo_r + {(STATE_W - DRAW_W)'(0), rem_r};
      default:  res_nxt = {(STATE_W - DRAW_W)'(0), draw_nxt};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) res_r <= res_nxt;
    if (cmd.out_load) out_r <= res_r;
  end

  assign stat.op        = op_r;
  assign stat.bounds_eq = eq_r;
  assign stat.div_last  = (cnt_r == DIV_LAST);
  assign out_value      = out_r;

endmodule

### design/ranged_lcg_random.sv
// Ranged LCG random generator: top level joining rlr_ctrl and rlr_dp.
// Depends on rlr_pkg, rlr_ctrl, rlr_dp.
//
// Each transfer on the input carries an operation in in_tuser: a raw draw
// returns bits 30..16 of the advanced 32-bit state; a seed load replaces the
// state and returns nothing; a ranged draw orders its bounds and returns
// low + draw mod (high - low), or the bound itself (state untouched) when the
// bounds are equal. Code 3 is dropped. One item is worked on at a time: a seed
// load or dropped code leaves the input ready; a raw draw or an equal-bound
// ranged draw passes the step and done states, other ranged draws also the
// 15-step bit-serial remainder unit and an add state. Done waits for a free
// output register, and a finished result sits there while the next item is taken.
`timescale 1ns / 1ps

module ranged_lcg_random (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // [31:0] seed_value, [63:32] range_low, [95:64] range_high
  input  logic [1:0]  in_tuser,  // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // [31:0] value
);
  import rlr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  op_t       in_op;

  assign in_op = op_t'(in_tuser);

  rlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_op),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_op    (in_op),
    .in_seed  (in_tdata[31:0]),
    .in_low   (in_tdata[63:32]),
    .in_high  (in_tdata[95:64]),
    .stat     (stat),
    .out_value(out_tdata)
  );

endmodule

### design/rlr_check.sv
// Port-level checker for ranged_lcg_random, attached by bind.
// Depends on rlr_pkg.
`timescale 1ns / 1ps

module rlr_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import rlr_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a drawing operation keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == OP_DRAW || in_tuser == OP_RANGE) |=> !in_tready)
    else $error("input taken again straight after a draw");

  // no result can appear the cycle after a transfer in
  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind ranged_lcg_random rlr_check u_rlr_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
